// ----- sv/grayscale_reconstruction_by_dilation_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for grayscale reconstruction by dilation
// Same-cycle and next-cycle implication checks with synchronous reset masking.
// ----------------------------------------------------------------------------
`ifndef GRAYSCALE_RECONSTRUCTION_BY_DILATION_ASSERT_SVH
`define GRAYSCALE_RECONSTRUCTION_BY_DILATION_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define GRBD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("grbd assertion failed");

// Antecedent implies consequent in the next cycle.
`define GRBD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("grbd assertion failed");

`endif

// ----- sv/grbd_pkg.sv -----
// ----------------------------------------------------------------------------
// grbd_pkg
// Shared codes and beat widths for the grayscale reconstruction block.
// ----------------------------------------------------------------------------
package grbd_pkg;

  localparam int IN_BITS  = 40;
  localparam int OUT_BITS = 16;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_RUN  = 2'd1,
    CMD_READ = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_CONN   = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PH_FWD  = 2'd0,
    PH_BWD  = 2'd1,
    PH_PROP = 2'd2
  } phase_t;

  // Neighbor directions, in the order propagation visits them.
  typedef enum logic [2:0] {
    DIR_N  = 3'd0,
    DIR_S  = 3'd1,
    DIR_W  = 3'd2,
    DIR_E  = 3'd3,
    DIR_NW = 3'd4,
    DIR_NE = 3'd5,
    DIR_SW = 3'd6,
    DIR_SE = 3'd7
  } dir_t;

endpackage

// ----- sv/grbd_nbr.sv -----
// ----------------------------------------------------------------------------
// grbd_nbr
// Neighbor position and eligibility for one direction in the current phase.
// ----------------------------------------------------------------------------
module grbd_nbr #(
  parameter int XW = 8,
  parameter int YW = 8
) (
  input  logic [XW-1:0]      x,
  input  logic [YW-1:0]      y,
  input  logic [XW-1:0]      mx,
  input  logic [YW-1:0]      my,
  input  logic               c8,
  input  grbd_pkg::phase_t   phase,
  input  grbd_pkg::dir_t     dir,
  output logic               used,
  output logic [XW-1:0]      qx,
  output logic [YW-1:0]      qy
);

  logic xm, xp, ym, yp, diag, in_set;

  always_comb begin
    xm = 1'b0;
    xp = 1'b0;
    ym = 1'b0;
    yp = 1'b0;
    case (dir)
      grbd_pkg::DIR_N:  ym = 1'b1;
      grbd_pkg::DIR_S:  yp = 1'b1;
      grbd_pkg::DIR_W:  xm = 1'b1;
      grbd_pkg::DIR_E:  xp = 1'b1;
      grbd_pkg::DIR_NW: begin xm = 1'b1; ym = 1'b1; end
      grbd_pkg::DIR_NE: begin xp = 1'b1; ym = 1'b1; end
      grbd_pkg::DIR_SW: begin xm = 1'b1; yp = 1'b1; end
      grbd_pkg::DIR_SE: begin xp = 1'b1; yp = 1'b1; end
      default: ;
    endcase
    diag = (xm | xp) & (ym | yp);
    // Forward scan looks at visited pixels above and left, backward below and right.
    case (phase)
      grbd_pkg::PH_FWD:  in_set = ym | (xm & ~yp);
      grbd_pkg::PH_BWD:  in_set = yp | (xp & ~ym);
      default:           in_set = 1'b1;
    endcase
    used = in_set & (~diag | c8)
         & (~xm | (x != '0)) & (~xp | (x != mx))
         & (~ym | (y != '0)) & (~yp | (y != my));
    qx = xm ? x - XW'(1) : (xp ? x + XW'(1) : x);
    qy = ym ? y - YW'(1) : (yp ? y + YW'(1) : y);
  end

endmodule

// ----- sv/grayscale_reconstruction_by_dilation.sv -----
// ----------------------------------------------------------------------------
// grayscale_reconstruction_by_dilation
// Marker-under-mask reconstruction by dilation, fast hybrid method, with
// mask, work and queue memories behind a stream command port.
// ----------------------------------------------------------------------------
//  Channel   Dir  Beat contents
//  s_axis    in   command, col, row, mask_value, marker_value
//  m_axis    out  pixel_out, overflow (one beat per command beat)
//  cfg       in   register index and write data
//
//  A read waits for the registered work memory read. A run reads each active
//  pixel in each of the two scans and then tries every one of the eight
//  directions in turn, with a further read for each eligible neighbor; it
//  does the same for each queue pop and ends on the empty queue. The single
//  read port of the work memory sets that.
//  Reset clears control state only; stores hold nothing until loaded.
//  One command is worked on at a time; a waiting result holds further beats.
// ----------------------------------------------------------------------------
module grayscale_reconstruction_by_dilation #(
  parameter int MAX_WIDTH   = 256,
  parameter int MAX_HEIGHT  = 256,
  parameter int PIXEL_BITS  = 8,
  parameter int QUEUE_DEPTH = 65536
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [1:0] command, [9:2] col, [17:10] row, [25:18] mask_value,
  // [33:26] marker_value, [39:34] zero
  input  logic [grbd_pkg::IN_BITS-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] pixel_out, [8] overflow, [15:9] zero
  output logic [grbd_pkg::OUT_BITS-1:0] m_axis_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [8:0]                    cfg_data
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int AW = XW + YW;
  localparam int PB = PIXEL_BITS;
  localparam int QW = $clog2(QUEUE_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_CTR, S_CTR_W, S_NB, S_NB_W, S_WR,
    S_POP, S_POP_W, S_PCTR_W, S_PNB, S_PNB_W
  } state_t;

  // Configuration registers
  logic [8:0] img_w;
  logic [8:0] img_h;
  logic       conn;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      img_w <= 9'd256;
      img_h <= 9'd256;
      conn  <= 1'b0;
    end else if (cfg_valid) begin
      case (grbd_pkg::cfg_idx_t'(cfg_index))
        grbd_pkg::CFG_WIDTH:  img_w <= cfg_data;
        grbd_pkg::CFG_HEIGHT: img_h <= cfg_data;
        grbd_pkg::CFG_CONN:   conn  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input beat fields
  grbd_pkg::cmd_t in_cmd;
  logic [7:0]     in_col, in_row, in_mask, in_marker;
  logic           in_inside;
  logic [AW-1:0]  in_a;
  logic           in_fire;

  assign in_cmd    = grbd_pkg::cmd_t'(s_axis_tdata[1:0]);
  assign in_col    = s_axis_tdata[9:2];
  assign in_row    = s_axis_tdata[17:10];
  assign in_mask   = s_axis_tdata[25:18];
  assign in_marker = s_axis_tdata[33:26];
  assign in_inside = (32'(in_col) < MAX_WIDTH) && (32'(in_row) < MAX_HEIGHT);
  assign in_a      = {YW'(in_row), XW'(in_col)};
  assign in_fire   = s_axis_tvalid && s_axis_tready;

  // Control and datapath registers
  state_t            state;
  grbd_pkg::phase_t  phase;
  grbd_pkg::dir_t    k;
  logic [XW-1:0]     x, mx, mx_eff;
  logic [YW-1:0]     y, my, my_eff;
  logic              c8;
  logic [PB-1:0]     p, ma;
  logic [7:0]        nbv;
  logic [PB-1:0]     nbw [8];
  logic [PB-1:0]     nbm [8];
  logic [QW-1:0]     head, tail;
  logic [QW:0]       count;
  logic              ovf;
  logic              out_valid;
  logic [7:0]        out_pix;
  logic              out_ovf;

  // Memories: one write and one registered read each
  logic [PB-1:0] work_mem [2**AW];
  logic [PB-1:0] mask_mem [2**AW];
  logic [AW-1:0] fifo_mem [QUEUE_DEPTH];

  logic [AW-1:0] rd_a, wk_wa;
  logic          wk_we, mk_we;
  logic [PB-1:0] wk_wd, wk_rd, mk_rd;
  logic [AW-1:0] fifo_rd;
  logic          push_req, push_ok;
  logic [AW-1:0] push_a;

  // Neighbor generator
  logic          nb_used;
  logic [XW-1:0] qx;
  logic [YW-1:0] qy;
  logic [AW-1:0] cur_a, q_a;

  grbd_nbr #(.XW(XW), .YW(YW)) u_nbr (
    .x(x), .y(y), .mx(mx), .my(my), .c8(c8), .phase(phase), .dir(k),
    .used(nb_used), .qx(qx), .qy(qy)
  );

  assign cur_a = {y, x};
  assign q_a   = {qy, qx};

  // Active region, clamped to the store
  always_comb begin
    if (img_w == 9'd0) mx_eff = '0;
    else if (32'(img_w) > MAX_WIDTH) mx_eff = XW'(MAX_WIDTH - 1);
    else mx_eff = XW'(img_w - 9'd1);
    if (img_h == 9'd0) my_eff = '0;
    else if (32'(img_h) > MAX_HEIGHT) my_eff = YW'(MAX_HEIGHT - 1);
    else my_eff = YW'(img_h - 9'd1);
  end

  // Scan result and the backward-pass queue test
  logic [PB-1:0] pf;
  logic          add;

  always_comb begin
    pf  = (p < ma) ? p : ma;
    add = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (nbv[i] && nbw[i] < pf && nbw[i] < nbm[i]) add = 1'b1;
    end
  end

  // Memory port steering
  always_comb begin
    case (state)
      S_IDLE:         rd_a = in_a;
      S_NB, S_PNB:    rd_a = q_a;
      S_POP_W:        rd_a = fifo_rd;
      default:        rd_a = cur_a;
    endcase
    wk_we    = 1'b0;
    wk_wa    = cur_a;
    wk_wd    = pf;
    mk_we    = 1'b0;
    push_req = 1'b0;
    push_a   = cur_a;
    case (state)
      S_IDLE: begin
        if (in_fire && in_cmd == grbd_pkg::CMD_LOAD && in_inside) begin
          wk_we = 1'b1;
          mk_we = 1'b1;
          wk_wa = in_a;
          wk_wd = PB'(in_marker);
        end
      end
      S_WR: begin
        wk_we    = 1'b1;
        push_req = (phase == grbd_pkg::PH_BWD) && add;
      end
      S_PNB_W: begin
        // Grow the neighbor towards the popped value, clipped by its mask
        if (wk_rd < p && mk_rd != wk_rd) begin
          wk_we    = 1'b1;
          wk_wa    = q_a;
          wk_wd    = (p < mk_rd) ? p : mk_rd;
          push_req = 1'b1;
          push_a   = q_a;
        end
      end
      default: ;
    endcase
    push_ok = push_req && (count != (QW+1)'(QUEUE_DEPTH));
  end

  always_ff @(posedge clk) begin
    if (wk_we) work_mem[wk_wa] <= wk_wd;
    wk_rd <= work_mem[rd_a];
  end

  always_ff @(posedge clk) begin
    if (mk_we) mask_mem[in_a] <= PB'(in_mask);
    mk_rd <= mask_mem[rd_a];
  end

  always_ff @(posedge clk) begin
    if (push_ok) fifo_mem[tail] <= push_a;
    fifo_rd <= fifo_mem[head];
  end

  assign s_axis_tready = (state == S_IDLE) && (!out_valid || m_axis_tready);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'd0, out_ovf, out_pix};

  // Sequencer: state, queue pointers and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= grbd_pkg::PH_FWD;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
      k         <= grbd_pkg::DIR_N;
    end else begin
      if (out_valid && m_axis_tready) out_valid <= 1'b0;

      // Queue push; a push into a full queue is dropped and flagged
      if (push_req) begin
        if (push_ok) begin
          tail  <= (tail == QW'(QUEUE_DEPTH - 1)) ? '0 : tail + QW'(1);
          count <= count + (QW+1)'(1);
        end else begin
          ovf <= 1'b1;
        end
      end

      case (state)
        S_IDLE: begin
          if (in_fire) begin
            out_pix <= 8'd0;
            out_ovf <= ovf;
            case (in_cmd)
              grbd_pkg::CMD_RUN: begin
                mx    <= mx_eff;
                my    <= my_eff;
                c8    <= conn;
                x     <= '0;
                y     <= '0;
                phase <= grbd_pkg::PH_FWD;
                head  <= '0;
                tail  <= '0;
                count <= '0;
                ovf   <= 1'b0;
                state <= S_CTR;
              end
              grbd_pkg::CMD_READ: begin
                if (in_inside) state <= S_READ;
                else out_valid <= 1'b1;
              end
              default: out_valid <= 1'b1;
            endcase
          end
        end
        S_READ: begin
          out_pix   <= 8'(wk_rd);
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        S_CTR: state <= S_CTR_W;
        S_CTR_W: begin
          p     <= wk_rd;
          ma    <= mk_rd;
          nbv   <= '0;
          k     <= grbd_pkg::DIR_N;
          state <= S_NB;
        end
        S_NB: begin
          if (nb_used) state <= S_NB_W;
          else if (k == grbd_pkg::DIR_SE) state <= S_WR;
          else k <= grbd_pkg::dir_t'(k + 3'd1);
        end
        S_NB_W: begin
          if (wk_rd > p) p <= wk_rd;
          nbw[k] <= wk_rd;
          nbm[k] <= mk_rd;
          nbv[k] <= 1'b1;
          if (k == grbd_pkg::DIR_SE) state <= S_WR;
          else begin
            k     <= grbd_pkg::dir_t'(k + 3'd1);
            state <= S_NB;
          end
        end
        S_WR: begin
          // Advance in raster order forward, anti-raster order backward
          state <= S_CTR;
          if (phase == grbd_pkg::PH_FWD) begin
            if (x == mx) begin
              x <= '0;
              if (y == my) begin
                phase <= grbd_pkg::PH_BWD;
                x     <= mx;
              end else begin
                y <= y + YW'(1);
              end
            end else begin
              x <= x + XW'(1);
            end
          end else begin
            if (x == '0) begin
              if (y == '0) begin
                phase <= grbd_pkg::PH_PROP;
                state <= S_POP;
              end else begin
                y <= y - YW'(1);
                x <= mx;
              end
            end else begin
              x <= x - XW'(1);
            end
          end
        end
        S_POP: begin
          if (count == '0) begin
            out_valid <= 1'b1;
            out_pix   <= 8'd0;
            out_ovf   <= ovf;
            state     <= S_IDLE;
          end else begin
            head  <= (head == QW'(QUEUE_DEPTH - 1)) ? '0 : head + QW'(1);
            count <= count - (QW+1)'(1);
            state <= S_POP_W;
          end
        end
        S_POP_W: begin
          x <= fifo_rd[XW-1:0];
          y <= fifo_rd[AW-1:XW];
          // Drop entries outside the active region
          if (fifo_rd[XW-1:0] > mx || fifo_rd[AW-1:XW] > my) state <= S_POP;
          else state <= S_PCTR_W;
        end
        S_PCTR_W: begin
          p     <= wk_rd;
          k     <= grbd_pkg::DIR_N;
          state <= S_PNB;
        end
        S_PNB: begin
          if (nb_used) state <= S_PNB_W;
          else if (k == grbd_pkg::DIR_SE) state <= S_POP;
          else k <= grbd_pkg::dir_t'(k + 3'd1);
        end
        S_PNB_W: begin
          if (k == grbd_pkg::DIR_SE) state <= S_POP;
          else begin
            k     <= grbd_pkg::dir_t'(k + 3'd1);
            state <= S_PNB;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/grbd_checker.sv -----
// ----------------------------------------------------------------------------
// grbd_checker
// Port-level checks on command and result beats, bound to the top level.
// ----------------------------------------------------------------------------
`include "grayscale_reconstruction_by_dilation_assert.svh"

module grbd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [grbd_pkg::IN_BITS-1:0]  s_axis_tdata,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [grbd_pkg::OUT_BITS-1:0] m_axis_tdata
);

  logic in_fire;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  // A result that is not taken holds
  `GRBD_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // No command beat while an earlier result still waits
  `GRBD_ASSERT_IMPLY(a_one_pending, clk, rst, s_axis_tready, !m_axis_tvalid || m_axis_tready)

  // A load answers in the next cycle
  `GRBD_ASSERT_NEXT(a_load_quick, clk, rst, in_fire && s_axis_tdata[1:0] == grbd_pkg::CMD_LOAD, m_axis_tvalid)

  // A run never answers in the next cycle
  `GRBD_ASSERT_NEXT(a_run_slow, clk, rst, in_fire && s_axis_tdata[1:0] == grbd_pkg::CMD_RUN, !m_axis_tvalid)

endmodule

bind grayscale_reconstruction_by_dilation grbd_checker u_grbd_checker (
  .clk(clk),
  .rst(rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tdata(s_axis_tdata),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);
